>>> rtl/edd_pkg.sv
// Shared constants, types and helpers of the error-diffusion dither block.
`default_nettype none

package edd_pkg;

    // Frame size limits and the index widths that follow from them
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);

    // Register widths
    localparam int THR_W      = 8;
    localparam int IMG_W_W    = 11;
    localparam int IMG_H_W    = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_ADDR_W = 2;

    // Pixel and error widths
    localparam int NUM_CH  = 3;
    localparam int PIX_W   = 8;
    localparam int ERR_W   = 9;                // error or share, -256..255
    localparam int WORD_W  = NUM_CH * ERR_W;   // one line store entry
    localparam int SUM_W   = 11;               // pixel + carry + error from above
    localparam int PROD_W  = 12;               // weight * error, |7*255| < 2048

    localparam logic signed [ERR_W-1:0] LEVEL_WHITE = 9'sd255;
    localparam logic signed [ERR_W-1:0] LEVEL_BLACK = 9'sd0;
    localparam logic [PIX_W-1:0]        PIX_MAX     = 8'd255;

    // Output queue
    localparam int OQ_DEPTH = 3;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    // Register reset values
    localparam logic [THR_W-1:0]   THR_RESET    = 8'd96;
    localparam logic [IMG_W_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [IMG_H_W-1:0] HEIGHT_RESET = 13'd480;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_THRESHOLD    = 2'd0,
        CFG_IMAGE_WIDTH  = 2'd1,
        CFG_IMAGE_HEIGHT = 2'd2
    } t_cfg_reg;

    // Position of one pixel and its line and frame flags
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic             row_nz;
        logic             last_col;
        logic             frame_end;
    } t_pos;

    // Line store write request
    typedef struct packed {
        logic              en;
        logic [COL_W-1:0]  addr;
        logic [WORD_W-1:0] data;
    } t_wr;

    // One result transaction
    typedef struct packed {
        logic              frame_end;
        logic              line_end;
        logic [NUM_CH-1:0] on;
    } t_result;

    // Signed divide by 16, truncating toward zero
    function automatic logic signed [ERR_W-1:0] div16(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] t;
        t = p[PROD_W-1] ? (p + PROD_W'(15)) : p;
        return ERR_W'(t >>> 4);
    endfunction

endpackage

`default_nettype wire

>>> rtl/edd_line_store.sv
// Line store of diffused error, one entry per column, with same-edge write forwarding.
`default_nettype none

module edd_line_store (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_rd_en,
    input  wire logic [edd_pkg::COL_W-1:0]        i_rd_addr,
    input  wire edd_pkg::t_wr                     i_wr,
    output logic      [edd_pkg::WORD_W-1:0]       o_rd_data
);

    logic [edd_pkg::WORD_W-1:0] r_mem [edd_pkg::MAX_WIDTH];
    logic [edd_pkg::WORD_W-1:0] r_rd_data;
    logic [edd_pkg::WORD_W-1:0] r_fwd_data;
    logic                       r_fwd;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_addr];
            r_fwd_data <= i_wr.data;
        end
    end

    // read-first array: a write landing on the read address at the same edge wins
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd <= i_wr.en && (i_wr.addr == i_rd_addr);
        end
    end

    assign o_rd_data = r_fwd ? r_fwd_data : r_rd_data;

endmodule

`default_nettype wire

>>> rtl/edd_position.sv
// Raster position tracker: column, row and line/frame end flags per accepted pixel.
`default_nettype none

module edd_position (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_accept,
    input  wire logic                           i_frame_start,
    input  wire logic [edd_pkg::IMG_W_W-1:0]    i_width,
    input  wire logic [edd_pkg::IMG_H_W-1:0]    i_height,
    output edd_pkg::t_pos                       o_pos
);

    logic [edd_pkg::COL_W-1:0]   r_col, n_col;
    logic [edd_pkg::ROW_W-1:0]   r_row, n_row;
    logic [edd_pkg::COL_W-1:0]   col;
    logic [edd_pkg::ROW_W-1:0]   row;
    logic [edd_pkg::IMG_W_W-1:0] w_use;
    logic [edd_pkg::IMG_H_W-1:0] h_use;
    logic                        last_col;
    logic                        last_row;

    // clamp sizes to 1..max
    always_comb begin
        if (i_width == '0) begin
            w_use = edd_pkg::IMG_W_W'(1);
        end else if (32'(i_width) > 32'(edd_pkg::MAX_WIDTH)) begin
            w_use = edd_pkg::IMG_W_W'(edd_pkg::MAX_WIDTH);
        end else begin
            w_use = i_width;
        end
        if (i_height == '0) begin
            h_use = edd_pkg::IMG_H_W'(1);
        end else if (32'(i_height) > 32'(edd_pkg::MAX_HEIGHT)) begin
            h_use = edd_pkg::IMG_H_W'(edd_pkg::MAX_HEIGHT);
        end else begin
            h_use = i_height;
        end
    end

    assign col      = i_frame_start ? '0 : r_col;
    assign row      = i_frame_start ? '0 : r_row;
    assign last_col = (32'(col) + 32'd1) >= 32'(w_use);
    assign last_row = (32'(row) + 32'd1) >= 32'(h_use);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_accept) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : row + edd_pkg::ROW_W'(1);
            end else begin
                n_col = col + edd_pkg::COL_W'(1);
                n_row = row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_pos.col       = col;
    assign o_pos.row_nz    = (row != '0);
    assign o_pos.last_col  = last_col;
    assign o_pos.frame_end = last_col && last_row;

endmodule

`default_nettype wire

>>> rtl/edd_diffuse.sv
// Threshold and error spreading stage; owns the carries and the line-end write-back.
`default_nettype none

module edd_diffuse (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_rst_n,
    input  wire logic                                        i_accept,
    input  wire edd_pkg::t_pos                               i_pos,
    input  wire logic [edd_pkg::NUM_CH-1:0][edd_pkg::PIX_W-1:0] i_pix,
    input  wire logic [edd_pkg::THR_W-1:0]                   i_thr,
    input  wire logic [edd_pkg::WORD_W-1:0]                  i_mem_data,
    output logic                                             o_busy,
    output edd_pkg::t_wr                                     o_wr,
    output logic                                             o_res_valid,
    output edd_pkg::t_result                                 o_res
);

    localparam int EW = edd_pkg::ERR_W;

    // stage register: pixel whose line store read is in flight
    logic                                            r_a_valid;
    edd_pkg::t_pos                                   r_pos;
    logic [edd_pkg::NUM_CH-1:0][edd_pkg::PIX_W-1:0]  r_pix;

    // per-channel carries
    logic signed [EW-1:0] r_rc  [edd_pkg::NUM_CH];
    logic signed [EW-1:0] r_pb  [edd_pkg::NUM_CH];
    logic signed [EW-1:0] r_pbr [edd_pkg::NUM_CH];
    logic signed [EW-1:0] n_rc  [edd_pkg::NUM_CH];
    logic signed [EW-1:0] n_pb  [edd_pkg::NUM_CH];
    logic signed [EW-1:0] n_pbr [edd_pkg::NUM_CH];

    // column below a line's last pixel, held in a register and written in the following cycle
    logic                           r_def_valid;
    logic [edd_pkg::COL_W-1:0]      r_def_addr;
    logic [edd_pkg::WORD_W-1:0]     r_def_data;
    logic [edd_pkg::WORD_W-1:0]     def_data;
    logic [edd_pkg::WORD_W-1:0]     left_data;

    logic                           col0;
    logic                           def_hit;
    logic [edd_pkg::NUM_CH-1:0]     on;

    assign col0    = (r_pos.col == '0);
    assign def_hit = r_def_valid && (r_def_addr == r_pos.col);

    always_comb begin
        logic signed [EW-1:0]                up;
        logic signed [EW-1:0]                rc;
        logic signed [EW-1:0]                pb;
        logic signed [EW-1:0]                pbr;
        logic signed [edd_pkg::SUM_W-1:0]    sum;
        logic [edd_pkg::PIX_W-1:0]           sat;
        logic signed [EW-1:0]                err;
        logic signed [edd_pkg::PROD_W-1:0]   e;
        logic signed [EW-1:0]                s7;
        logic signed [EW-1:0]                s5;
        logic signed [EW-1:0]                s3;
        logic signed [EW-1:0]                s1;
        on        = '0;
        left_data = '0;
        def_data  = '0;
        for (int c = 0; c < edd_pkg::NUM_CH; c++) begin
            if (!r_pos.row_nz) begin
                up = '0;
            end else if (def_hit) begin
                up = $signed(r_def_data[c*EW +: EW]);
            end else begin
                up = $signed(i_mem_data[c*EW +: EW]);
            end
            rc  = col0 ? '0 : r_rc[c];
            pb  = col0 ? '0 : r_pb[c];
            pbr = col0 ? '0 : r_pbr[c];

            sum = $signed(edd_pkg::SUM_W'(r_pix[c])) + edd_pkg::SUM_W'(rc)
                + edd_pkg::SUM_W'(up);
            if (sum < 0) begin
                sat = '0;
            end else if (sum > 255) begin
                sat = edd_pkg::PIX_MAX;
            end else begin
                sat = sum[edd_pkg::PIX_W-1:0];
            end
            on[c] = sat > i_thr;
            err   = $signed({1'b0, sat})
                  - (on[c] ? edd_pkg::LEVEL_WHITE : edd_pkg::LEVEL_BLACK);

            e  = edd_pkg::PROD_W'(err);
            s7 = edd_pkg::div16((e <<< 3) - e);
            s5 = edd_pkg::div16((e <<< 2) + e);
            s3 = edd_pkg::div16((e <<< 1) + e);
            s1 = edd_pkg::div16(e);

            left_data[c*EW +: EW] = pb + s3;
            n_pb[c]               = pbr + s5;
            def_data[c*EW +: EW]  = n_pb[c];
            n_pbr[c]              = s1;
            n_rc[c]               = r_pos.last_col ? '0 : s7;
            if (r_pos.last_col) begin
                n_pb[c]  = '0;
                n_pbr[c] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_pos <= i_pos;
            r_pix <= i_pix;
        end
        if (r_a_valid) begin
            r_rc  <= n_rc;
            r_pb  <= n_pb;
            r_pbr <= n_pbr;
        end
        if (r_a_valid && r_pos.last_col) begin
            r_def_addr <= r_pos.col;
            r_def_data <= def_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_def_valid <= 1'b0;
        end else begin
            r_a_valid   <= i_accept;
            r_def_valid <= r_a_valid && r_pos.last_col;
        end
    end

    // The pixel after a line end sits in column 0 and writes nothing,
    // so the late write never meets a normal one.
    always_comb begin
        o_wr = '0;
        if (r_a_valid && !col0) begin
            o_wr.en   = 1'b1;
            o_wr.addr = r_pos.col - edd_pkg::COL_W'(1);
            o_wr.data = left_data;
        end else if (r_def_valid) begin
            o_wr.en   = 1'b1;
            o_wr.addr = r_def_addr;
            o_wr.data = r_def_data;
        end
    end

    assign o_busy          = r_a_valid;
    assign o_res_valid     = r_a_valid;
    assign o_res.on        = on;
    assign o_res.line_end  = r_pos.last_col;
    assign o_res.frame_end = r_pos.frame_end;

endmodule

`default_nettype wire

>>> rtl/edd_out_queue.sv
// Small result queue between the datapath and the output stream.
`default_nettype none

module edd_out_queue (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire edd_pkg::t_result     i_data,
    input  wire logic                 i_inflight,
    output logic                      o_room,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output edd_pkg::t_result          o_data
);

    edd_pkg::t_result                r_q [edd_pkg::OQ_DEPTH];
    logic [edd_pkg::OQ_PTR_W-1:0]    r_wr, r_rd;
    logic [edd_pkg::OQ_CNT_W-1:0]    r_cnt;
    logic                            pop;

    function automatic logic [edd_pkg::OQ_PTR_W-1:0] inc(input logic [edd_pkg::OQ_PTR_W-1:0] p);
        return (32'(p) == edd_pkg::OQ_DEPTH - 1) ? '0 : p + edd_pkg::OQ_PTR_W'(1);
    endfunction

    assign pop     = o_valid && i_ready;
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_q[r_rd];
    // room for one more pixel counting the one still in the datapath
    assign o_room  = (32'(r_cnt) + 32'(i_inflight)) < edd_pkg::OQ_DEPTH;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= inc(r_wr);
            end
            if (pop) begin
                r_rd <= inc(r_rd);
            end
            if (i_push && !pop) begin
                r_cnt <= r_cnt + edd_pkg::OQ_CNT_W'(1);
            end else if (pop && !i_push) begin
                r_cnt <= r_cnt - edd_pkg::OQ_CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/error_diffusion_dither_top.sv
// Top level of the Floyd-Steinberg error-diffusion dither.
`default_nettype none

// Floyd-Steinberg dither for an RGB pixel stream in raster order. Each
// channel adds the error diffused to it, saturates to 0..255 and compares
// with the threshold register: above it the output bit is 1 (full white).
// The error is spread 7/16 right, 3/16 below-left, 5/16 below, 1/16
// below-right, shares truncated toward zero and dropped at the image edges;
// every channel keeps its own error. One pixel per clock is taken while the
// result queue has room and one result per pixel comes out; the rate is set
// by the line store, a single-port-write array of one 27-bit entry per
// column that is read once and written once per pixel. Rows below row 0 use
// what the row above left in the store, so after the width grows the first
// row below must not reach columns never written. tuser on the input marks
// the first pixel of a frame and restarts the position at row 0, column 0.
// A three-deep result queue keeps the input moving while the output stalls.
// Registers (write only, take effect for following pixels, write while
// idle): 0 threshold (8 bit, reset 96), 1 image width (11 bit, clamped to
// 1..1024, reset 640), 2 image height (13 bit, clamped to 1..4096, reset
// 480). Writes to other indexes are ignored.

module error_diffusion_dither_top (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,

    input  wire logic                               i_cfg_we,
    input  wire logic [edd_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  wire logic [edd_pkg::CFG_DATA_W-1:0]     i_cfg_data,

    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [23:0]                        s_axis_tdata,  // red_in, green_in, blue_in
    input  wire logic                               s_axis_tuser,  // frame_start

    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [7:0]                              m_axis_tdata,  // red_on, green_on, blue_on, zeros
    output logic                                    m_axis_tlast,  // line_end
    output logic                                    m_axis_tuser   // frame_end
);

    logic [edd_pkg::THR_W-1:0]   r_threshold;
    logic [edd_pkg::IMG_W_W-1:0] r_width;
    logic [edd_pkg::IMG_H_W-1:0] r_height;

    logic                        accept;
    logic                        room;
    logic                        busy;
    edd_pkg::t_pos               pos;
    edd_pkg::t_wr                wr;
    logic [edd_pkg::WORD_W-1:0]  mem_data;
    logic                        res_valid;
    edd_pkg::t_result            res;
    edd_pkg::t_result            out_res;
    logic [edd_pkg::NUM_CH-1:0][edd_pkg::PIX_W-1:0] pix;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= edd_pkg::THR_RESET;
            r_width     <= edd_pkg::WIDTH_RESET;
            r_height    <= edd_pkg::HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (edd_pkg::t_cfg_reg'(i_cfg_addr))
                edd_pkg::CFG_THRESHOLD:    r_threshold <= i_cfg_data[edd_pkg::THR_W-1:0];
                edd_pkg::CFG_IMAGE_WIDTH:  r_width     <= i_cfg_data[edd_pkg::IMG_W_W-1:0];
                edd_pkg::CFG_IMAGE_HEIGHT: r_height    <= i_cfg_data[edd_pkg::IMG_H_W-1:0];
                default: ;
            endcase
        end
    end

    // input transaction
    assign s_axis_tready = room;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign pix[0]        = s_axis_tdata[7:0];
    assign pix[1]        = s_axis_tdata[15:8];
    assign pix[2]        = s_axis_tdata[23:16];

    edd_position u_position (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_frame_start (s_axis_tuser),
        .i_width       (r_width),
        .i_height      (r_height),
        .o_pos         (pos)
    );

    // line store read issued at the accepting edge, data in the next cycle
    edd_line_store u_line_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (pos.col),
        .i_wr      (wr),
        .o_rd_data (mem_data)
    );

    edd_diffuse u_diffuse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_pos       (pos),
        .i_pix       (pix),
        .i_thr       (r_threshold),
        .i_mem_data  (mem_data),
        .o_busy      (busy),
        .o_wr        (wr),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    edd_out_queue u_out_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (res_valid),
        .i_data     (res),
        .i_inflight (busy),
        .o_room     (room),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_data     (out_res)
    );

    assign m_axis_tdata = {5'b0, out_res.on};
    assign m_axis_tlast = out_res.line_end;
    assign m_axis_tuser = out_res.frame_end;

endmodule

`default_nettype wire
